@@ rtl/assert_macros.svh @@
// Assertion macros shared by the biquad cascade RTL.
// Users include this header by its bare name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BQC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bqc assertion failed");
`define BQC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bqc assertion failed during or after reset");
`else
`define BQC_ASSERT(lbl, prop)
`define BQC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/bqc_pkg.sv @@
// Package for the biquad cascade filter: sizes, slot codes and transfer types.
// Used by bqc_cell and biquad_cascade_filter_top; depends on nothing.
`timescale 1ns / 1ps
package bqc_pkg;

  localparam int MAX_STAGES     = 8;
  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 30;

  localparam int COEF_W    = 32;
  localparam int NUM_SLOTS = 5;
  localparam int SLOT_W    = 3;
  localparam int STAGE_W   = 3;
  localparam int NSTG_W    = 4;
  localparam int DITH_W    = 9;

  localparam int PROD_W = COEF_W + SAMPLE_WIDTH;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SH_W   = ACC_W - COEF_FRAC_BITS;
  localparam int NEFF_W = $clog2(MAX_STAGES + 1);
  localparam int CELL_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  localparam logic [SLOT_W-1:0] SLOT_B0 = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_B1 = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_B2 = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_A1 = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_A2 = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_END = SLOT_W'(NUM_SLOTS);

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  typedef struct packed {
    logic                           command;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           block_end_in;
    logic [STAGE_W-1:0]             coef_stage;
    logic [SLOT_W-1:0]              coef_slot;
    logic signed [COEF_W-1:0]       coef_value;
  } bqc_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           block_end_out;
  } bqc_out_t;

  typedef struct packed {
    logic              start;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [COEF_W-1:0] wr_value;
  } bqc_cell_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bqc_cell_sts_t;

endpackage

@@ rtl/bqc_cell.sv @@
// One biquad section of the cascade: coefficients, history and a shared MAC.
// Depends on bqc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bqc_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bqc_pkg::bqc_cell_ctl_t                 ctl_i,
  input  logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] x_i,
  input  logic signed [bqc_pkg::ACC_W-1:0]        bias_i,
  output logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] y_o,
  output bqc_pkg::bqc_cell_sts_t                 sts_o
);
  import bqc_pkg::*;

  logic [COEF_W-1:0]              coef_q [NUM_SLOTS];
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [SLOT_W-1:0]              cnt_q, cnt_d;
  logic                           prod_vld_q, prod_vld_d;
  logic                           prod_sub_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q, x1_q, x2_q, y1_q, y2_q, y_q;
  logic signed [SAMPLE_WIDTH-1:0] op;
  logic signed [COEF_W-1:0]       coef_rd;
  logic signed [PROD_W-1:0]       prod_d;
  logic signed [ACC_W-1:0]        prod_ext, addend, sum;
  logic [SH_W-1:0]                sh;
  logic [SH_W-SAMPLE_WIDTH:0]     top_bits;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           fin;

  always_comb begin
    case (cnt_q)
      SLOT_B0: op = x_q;
      SLOT_B1: op = x1_q;
      SLOT_B2: op = x2_q;
      SLOT_A1: op = y1_q;
      SLOT_A2: op = y2_q;
      default: op = x_q;
    endcase
  end

  assign coef_rd = (cnt_q < SLOT_END) ? $signed(coef_q[cnt_q]) : '0;
  assign prod_d  = coef_rd * op;

  assign prod_ext = ACC_W'(prod_q);
  assign addend   = prod_sub_q ? -prod_ext : prod_ext;
  assign sum      = acc_q + addend;
  assign sh       = sum[ACC_W-1:COEF_FRAC_BITS];
  assign top_bits = sh[SH_W-1:SAMPLE_WIDTH-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      y_sat = $signed(sh[SAMPLE_WIDTH-1:0]);
    end else if (sh[SH_W-1]) begin
      y_sat = $signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
    end else begin
      y_sat = $signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    end
  end

  assign fin = busy_q && (cnt_q == SLOT_END) && !ctl_i.start;

  always_comb begin
    busy_d     = busy_q;
    cnt_d      = cnt_q;
    prod_vld_d = prod_vld_q;
    done_d     = 1'b0;
    if (ctl_i.start) begin
      busy_d     = 1'b1;
      cnt_d      = SLOT_B0;
      prod_vld_d = 1'b0;
    end else if (busy_q) begin
      if (cnt_q < SLOT_END) begin
        cnt_d      = cnt_q + 1'b1;
        prod_vld_d = 1'b1;
      end else begin
        busy_d     = 1'b0;
        prod_vld_d = 1'b0;
        done_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
      cnt_q      <= SLOT_B0;
      prod_vld_q <= 1'b0;
      x1_q       <= '0;
      x2_q       <= '0;
      y1_q       <= '0;
      y2_q       <= '0;
    end else begin
      busy_q     <= busy_d;
      done_q     <= done_d;
      cnt_q      <= cnt_d;
      prod_vld_q <= prod_vld_d;
      if (fin) begin
        x1_q <= x_q;
        x2_q <= x1_q;
        y1_q <= y_sat;
        y2_q <= y1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      coef_q[ctl_i.wr_slot] <= ctl_i.wr_value;
    end
    if (ctl_i.start) begin
      x_q   <= x_i;
      acc_q <= bias_i;
    end else if (busy_q) begin
      if (prod_vld_q) begin
        acc_q <= sum;
      end
      if (cnt_q < SLOT_END) begin
        prod_q     <= prod_d;
        prod_sub_q <= (cnt_q >= SLOT_A1);
      end
    end
    if (fin) begin
      y_q <= y_sat;
    end
  end

  assign y_o        = y_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

  `BQC_ASSERT(a_start_when_idle, ctl_i.start |-> !busy_q)
  `BQC_ASSERT(a_done_ends_busy, done_q |-> !busy_q && $past(busy_q))
  `BQC_ASSERT(a_cnt_in_range, busy_q |-> cnt_q <= SLOT_END)
  `BQC_ASSERT(a_no_write_while_busy, ctl_i.wr_en |-> !busy_q)

endmodule

@@ rtl/biquad_cascade_filter_top.sv @@
// Top level of the cascaded direct-form-I biquad filter with its APB registers.
// Depends on bqc_pkg, bqc_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A filter transfer runs the sample through num_stages biquad cells in turn; each cell
// multiplies its five coefficients one after another on its own 32x24 multiplier, then
// finishes its output and hands it over to the next cell. No new input is taken until the
// sample has left the last cell (or bypassed the cascade when num_stages is zero) and the
// output register has room. A coefficient write produces no output transfer and leaves the
// cascade idle. The finished sample sits in an output register, so the cascade is free
// again as soon as that register has room.
module biquad_cascade_filter_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bqc_pkg::bqc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bqc_pkg::bqc_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bqc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam logic REG_NUM_STAGES = 1'b0;
  localparam logic REG_DITHER     = 1'b1;

  logic [1:0]                     state_q, state_d;
  logic [NSTG_W-1:0]              num_stages_q;
  logic [DITH_W-1:0]              dither_q;
  logic                           sign_q;
  logic                           pass_q;
  logic                           blk_q;
  logic signed [SAMPLE_WIDTH-1:0] samp_q;
  logic                           out_valid_q;
  bqc_out_t                       out_q;

  logic                           in_acc, filt_acc, coef_acc, coef_ok, out_free, cfg_wr;
  logic [NEFF_W-1:0]              n_eff;
  logic [CELL_W-1:0]              last_idx;
  logic signed [DITH_W:0]         dith_ext, dval;
  logic signed [ACC_W-1:0]        bias;

  bqc_cell_ctl_t                  ctl   [MAX_STAGES];
  bqc_cell_sts_t                  sts   [MAX_STAGES];
  logic signed [SAMPLE_WIDTH-1:0] y_vec [MAX_STAGES];
  logic [MAX_STAGES-1:0]          busy_vec;
  logic                           last_done;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign filt_acc   = in_acc && (in_data_i.command == CMD_FILTER);
  assign coef_acc   = in_acc && (in_data_i.command == CMD_COEF);
  assign coef_ok    = (in_data_i.coef_slot < SLOT_END) &&
                      (int'(in_data_i.coef_stage) < MAX_STAGES);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    if (int'(num_stages_q) > MAX_STAGES) begin
      n_eff = NEFF_W'(MAX_STAGES);
    end else begin
      n_eff = NEFF_W'(num_stages_q);
    end
  end
  assign last_idx = CELL_W'(n_eff - 1'b1);

  assign dith_ext = {dither_q[DITH_W-1], dither_q};
  assign dval     = sign_q ? -dith_ext : dith_ext;
  assign bias     = (ACC_W'(dval) <<< COEF_FRAC_BITS) |
                    (ACC_W'(1) << (COEF_FRAC_BITS - 1));

  for (genvar s = 0; s < MAX_STAGES; s++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] x_in;
    if (s == 0) begin : g_first
      assign ctl[s].start = filt_acc && (n_eff != '0);
      assign x_in         = in_data_i.sample_in;
    end else begin : g_next
      assign ctl[s].start = sts[s-1].done && (s < int'(n_eff));
      assign x_in         = y_vec[s-1];
    end
    assign ctl[s].wr_en    = coef_acc && coef_ok && (int'(in_data_i.coef_stage) == s);
    assign ctl[s].wr_slot  = in_data_i.coef_slot;
    assign ctl[s].wr_value = in_data_i.coef_value;
    assign busy_vec[s]     = sts[s].busy;

    bqc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[s]),
      .x_i    (x_in),
      .bias_i (bias),
      .y_o    (y_vec[s]),
      .sts_o  (sts[s])
    );
  end

  assign last_done = sts[last_idx].done;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (filt_acc) begin
          state_d = (n_eff == '0) ? ST_HOLD : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_HOLD) && out_free) begin
        out_valid_q <= 1'b1;
        sign_q      <= !sign_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (filt_acc) begin
      samp_q <= in_data_i.sample_in;
      blk_q  <= in_data_i.block_end_in;
      pass_q <= (n_eff == '0);
    end
    if ((state_q == ST_HOLD) && out_free) begin
      out_q.sample_out    <= pass_q ? samp_q : y_vec[last_idx];
      out_q.block_end_out <= blk_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_stages_q <= '0;
      dither_q     <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_NUM_STAGES: num_stages_q <= pwdata[NSTG_W-1:0];
        REG_DITHER:     dither_q     <= pwdata[DITH_W-1:0];
        default:        num_stages_q <= num_stages_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_STAGES: prdata = 32'(num_stages_q);
      REG_DITHER:     prdata = 32'($signed(dither_q));
      default:        prdata = '0;
    endcase
  end

  `BQC_ASSERT(a_last_done_in_run, last_done |-> state_q == ST_RUN)
  `BQC_ASSERT(a_one_cell_busy, $onehot0(busy_vec))
  `BQC_ASSERT(a_hold_drains, (state_q == ST_HOLD) && out_free |=> out_valid_o && (state_q == ST_IDLE))
  `BQC_ASSERT_ALWAYS(a_reset_clears_out, !rst_ni |=> !out_valid_o)

endmodule
